// File: sv/ray_cylinder_side_and_distance_core_assert.svh
// Assertion macros used by the top-level core file.
`ifndef RAY_CYLINDER_SIDE_AND_DISTANCE_CORE_ASSERT_SVH
`define RAY_CYLINDER_SIDE_AND_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCSD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rcsd assertion failed");
`define RCSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcsd assertion failed");
`else
`define RCSD_ASSERT(lbl, expr)
`define RCSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/rcsd_pkg.sv
package rcsd_pkg;
    localparam int POS_W  = 32;
    localparam int DIR_W  = 16;
    localparam int DXW    = 33;
    localparam int KW     = 50;
    localparam int KMW    = 49;
    localparam int AW     = 32;
    localparam int CMW    = 67;
    localparam int QW     = 98;
    localparam int SW     = 49;
    localparam int REMW   = 53;
    localparam int NUMW   = 51;
    localparam int DVW    = 32;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CENTER_Z = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RADIUS   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TOL      = 3'd3;

    typedef struct packed {
        logic                 side;
        logic                 nohit;
        logic                 surf;
        logic                 cneg;
        logic signed [KW-1:0] k;
        logic [AW-1:0]        a;
    } t_item;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [SW-1:0]   root;
        logic [QW-1:0]   rad;
        t_item           item;
    } t_sq;

    typedef struct packed {
        logic            side;
        logic            nohit;
        logic            ovf;
        logic [AW-1:0]   a;
        logic [AW-1:0]   rem;
        logic [AW-1:0]   low;
        logic [DVW-1:0]  quo;
    } t_dv;
endpackage

// File: sv/rcsd_sqrt_cell.sv
module rcsd_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rcsd_pkg::t_sq  i_d,
    output logic           o_valid,
    output rcsd_pkg::t_sq  o_d
);
    import rcsd_pkg::*;

    logic [REMW-1:0] sh;
    logic [REMW-1:0] trial;
    logic            ge;
    t_sq             n_d;
    logic            r_valid;
    t_sq             r_d;

    assign sh    = {i_d.rem[REMW-3:0], i_d.rad[QW-1 -: 2]};
    assign trial = {{(REMW-SW-2){1'b0}}, i_d.root, 2'b01};
    assign ge    = sh >= trial;

    always_comb begin
        n_d      = i_d;
        n_d.rem  = ge ? (sh - trial) : sh;
        n_d.root = {i_d.root[SW-2:0], ge};
        n_d.rad  = {i_d.rad[QW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

// File: sv/rcsd_div_cell.sv
module rcsd_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rcsd_pkg::t_dv  i_d,
    output logic           o_valid,
    output rcsd_pkg::t_dv  o_d
);
    import rcsd_pkg::*;

    logic [AW:0] sh;
    logic [AW:0] diff;
    logic        ge;
    t_dv         n_d;
    logic        r_valid;
    t_dv         r_d;

    assign sh   = {i_d.rem, i_d.low[AW-1]};
    assign diff = sh - {1'b0, i_d.a};
    assign ge   = sh >= {1'b0, i_d.a};

    always_comb begin
        n_d     = i_d;
        n_d.rem = ge ? diff[AW-1:0] : sh[AW-1:0];
        n_d.low = {i_d.low[AW-2:0], 1'b0};
        n_d.quo = {i_d.quo[DVW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

// File: sv/rcsd_front.sv
module rcsd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [rcsd_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [rcsd_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [rcsd_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [rcsd_pkg::DIR_W-1:0]  i_dir_z,
    input  logic                               i_on_surface,
    input  logic signed [rcsd_pkg::POS_W-1:0]  i_center_x,
    input  logic signed [rcsd_pkg::POS_W-1:0]  i_center_z,
    input  logic [30:0]                        i_radius,
    input  logic [31:0]                        i_tol,
    output logic                               o_valid,
    output rcsd_pkg::t_sq                      o_d
);
    import rcsd_pkg::*;

    logic [6:0] r_vld;

    logic signed [DXW-1:0]   r1_dx, r1_dz;
    logic signed [DIR_W-1:0] r1_ux, r1_uz;
    logic                    r1_surf;

    logic [DXW-1:0]          mx, mz;
    logic signed [31:0]      uxx, uzz;
    logic [65:0]             r2_pxx, r2_pzz;
    logic signed [48:0]      r2_kx, r2_kz;
    logic [AW-1:0]           r2_a;
    logic [61:0]             r2_r2;
    logic                    r2_surf;

    logic [CMW-1:0]          r3_sum;
    logic signed [KW-1:0]    r3_k;
    logic [AW-1:0]           r3_a;
    logic [61:0]             r3_r2;
    logic                    r3_surf;

    logic [CMW-1:0]          r2x;
    logic                    cneg;
    logic [KW-1:0]           kneg;
    logic [CMW-1:0]          r4_cmag;
    logic                    r4_cneg;
    logic [KMW-1:0]          r4_km;
    logic signed [KW-1:0]    r4_k;
    logic [AW-1:0]           r4_a;
    logic                    r4_surf;

    logic                    cband, cbelow;
    logic [65:0]             r5_pa0;
    logic [64:0]             r5_pa1;
    logic [49:0]             r5_khh;
    logic [48:0]             r5_khl;
    logic [47:0]             r5_kll;
    t_item                   r5_it;

    logic [98:0]             r6_prod;
    logic [97:0]             r6_kk;
    t_item                   r6_it;

    logic [98:0]             kk_x, q_sum, q_dif;
    logic                    miss;
    t_sq                     n7_d;
    t_sq                     r7_d;

    assign mx  = r1_dx[DXW-1] ? (~r1_dx + 1'b1) : r1_dx;
    assign mz  = r1_dz[DXW-1] ? (~r1_dz + 1'b1) : r1_dz;
    assign uxx = r1_ux * r1_ux;
    assign uzz = r1_uz * r1_uz;

    assign r2x  = {5'b0, r3_r2};
    assign cneg = r3_sum < r2x;
    assign kneg = -r3_k;

    assign cband  = r4_cmag <= {35'b0, i_tol};
    assign cbelow = r4_cmag <  {35'b0, i_tol};

    assign kk_x  = {1'b0, r6_kk};
    assign q_sum = kk_x + r6_prod;
    assign q_dif = kk_x - r6_prod;
    assign miss  = !r6_it.cneg && (r6_prod > kk_x);

    always_comb begin
        n7_d          = '0;
        n7_d.rad      = r6_it.cneg ? q_sum[QW-1:0] : q_dif[QW-1:0];
        n7_d.item     = r6_it;
        n7_d.item.nohit = (r6_it.a == '0) || miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
        if (i_en) begin
            r1_dx   <= $signed({i_pos_x[POS_W-1], i_pos_x})
                     - $signed({i_center_x[POS_W-1], i_center_x});
            r1_dz   <= $signed({i_pos_z[POS_W-1], i_pos_z})
                     - $signed({i_center_z[POS_W-1], i_center_z});
            r1_ux   <= i_dir_x;
            r1_uz   <= i_dir_z;
            r1_surf <= i_on_surface;

            r2_pxx  <= mx * mx;
            r2_pzz  <= mz * mz;
            r2_kx   <= r1_dx * r1_ux;
            r2_kz   <= r1_dz * r1_uz;
            r2_a    <= $unsigned(uxx) + $unsigned(uzz);
            r2_r2   <= i_radius * i_radius;
            r2_surf <= r1_surf;

            r3_sum  <= {1'b0, r2_pxx} + {1'b0, r2_pzz};
            r3_k    <= $signed({r2_kx[48], r2_kx}) + $signed({r2_kz[48], r2_kz});
            r3_a    <= r2_a;
            r3_r2   <= r2_r2;
            r3_surf <= r2_surf;

            r4_cmag <= cneg ? (r2x - r3_sum) : (r3_sum - r2x);
            r4_cneg <= cneg;
            r4_km   <= r3_k[KW-1] ? kneg[KMW-1:0] : r3_k[KMW-1:0];
            r4_k    <= r3_k;
            r4_a    <= r3_a;
            r4_surf <= r3_surf;

            r5_pa0  <= r4_a * r4_cmag[33:0];
            r5_pa1  <= r4_a * r4_cmag[CMW-1:34];
            r5_khh  <= r4_km[48:24] * r4_km[48:24];
            r5_khl  <= r4_km[48:24] * r4_km[23:0];
            r5_kll  <= r4_km[23:0] * r4_km[23:0];
            r5_it.side  <= cband ? (!r4_k[KW-1] && (r4_k != '0)) : !r4_cneg;
            r5_it.nohit <= 1'b0;
            r5_it.surf  <= r4_surf || cbelow;
            r5_it.cneg  <= r4_cneg;
            r5_it.k     <= r4_k;
            r5_it.a     <= r4_a;

            r6_prod <= {33'b0, r5_pa0} + {r5_pa1, 34'b0};
            r6_kk   <= {r5_khh, 48'b0} + {24'b0, r5_khl, 25'b0} + {50'b0, r5_kll};
            r6_it   <= r5_it;

            r7_d    <= n7_d;
        end
    end

    assign o_valid = r_vld[6];
    assign o_d     = r7_d;
endmodule

// File: sv/ray_cylinder_side_and_distance_core.sv
// Side test and ray distance against an infinite cylinder parallel to y. Each
// transfer on the input stream yields one result transfer, through 7 front
// stages for the products and the quadratic discriminant, a chain of 49
// square-root cells (one root bit per cell), one stage for the root selection,
// a chain of 32 divider cells (one quotient bit per cell) and the output
// register. One item enters every cycle while the output skid register is
// empty; it lets the block take a transfer while a result waits. Configuration
// writes take effect at once and must only be made while the block is idle.
module ray_cylinder_side_and_distance_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [95:0]                 i_s_tdata,  // pos_x, pos_z, dir_x, dir_z
    input  logic                        i_s_tuser,  // on_surface
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [31:0]                 o_m_tdata,  // hit_distance
    output logic [1:0]                  o_m_tuser,  // side_positive, no_hit
    input  logic                        i_cfg_we,
    input  logic [rcsd_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                 i_cfg_data
);
    import rcsd_pkg::*;
`include "ray_cylinder_side_and_distance_core_assert.svh"

    logic signed [POS_W-1:0] r_center_x, r_center_z;
    logic [30:0]             r_radius;
    logic [31:0]             r_tol;

    logic                    en;
    logic                    w_sq_v [0:SW];
    t_sq                     w_sq_d [0:SW];
    logic                    w_dv_v [0:DVW];
    t_dv                     w_dv_d [0:DVW];

    t_item                   it;
    logic signed [NUMW-1:0]  kx, nk, s51, num_p, num_m, num;
    logic [63:0]             dvd;
    t_dv                     n_nm;
    logic                    r_nm_v;
    t_dv                     r_nm_d;

    t_dv                     last;
    logic [33:0]             res;
    logic                    r_out_valid, r_skid_full;
    logic [33:0]             r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_z <= '0;
            r_radius   <= '0;
            r_tol      <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                CFG_TOL:      r_tol      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_skid_full;
    assign o_s_tready = en;

    rcsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_s_tvalid),
        .i_pos_x      (i_s_tdata[31:0]),
        .i_pos_z      (i_s_tdata[63:32]),
        .i_dir_x      (i_s_tdata[79:64]),
        .i_dir_z      (i_s_tdata[95:80]),
        .i_on_surface (i_s_tuser),
        .i_center_x   (r_center_x),
        .i_center_z   (r_center_z),
        .i_radius     (r_radius),
        .i_tol        (r_tol),
        .o_valid      (w_sq_v[0]),
        .o_d          (w_sq_d[0])
    );

    for (genvar g = 0; g < SW; g++) begin : g_sq
        rcsd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[g]),
            .i_d     (w_sq_d[g]),
            .o_valid (w_sq_v[g+1]),
            .o_d     (w_sq_d[g+1])
        );
    end

    assign it    = w_sq_d[SW].item;
    assign kx    = $signed({it.k[KW-1], it.k});
    assign nk    = -kx;
    assign s51   = $signed({2'b00, w_sq_d[SW].root});
    assign num_p = nk + s51;
    assign num_m = nk - s51;
    assign num   = (it.surf || it.cneg) ? num_p : num_m;
    assign dvd   = {num[49:0], 14'b0};

    always_comb begin
        n_nm       = '0;
        n_nm.side  = it.side;
        n_nm.nohit = it.nohit ||
                     (it.surf ? !it.k[KW-1] : (!it.cneg && num_m[NUMW-1]));
        n_nm.ovf   = dvd[63:32] >= it.a;
        n_nm.a     = it.a;
        n_nm.rem   = dvd[63:32];
        n_nm.low   = dvd[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v <= 1'b0;
        end else if (en) begin
            r_nm_v <= w_sq_v[SW];
        end
        if (en) begin
            r_nm_d <= n_nm;
        end
    end

    assign w_dv_v[0] = r_nm_v;
    assign w_dv_d[0] = r_nm_d;

    for (genvar g = 0; g < DVW; g++) begin : g_dv
        rcsd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_dv_v[g]),
            .i_d     (w_dv_d[g]),
            .o_valid (w_dv_v[g+1]),
            .o_d     (w_dv_d[g+1])
        );
    end

    assign last = w_dv_d[DVW];
    assign res  = {last.nohit, last.side,
                   (last.nohit || last.ovf) ? 32'hFFFF_FFFF : last.quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (i_m_tready) begin
                r_out_valid <= 1'b1;
                r_skid_full <= 1'b0;
            end
        end else if (w_dv_v[DVW]) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_skid_full) begin
            if (i_m_tready) begin
                r_out <= r_skid;
            end
        end else if (w_dv_v[DVW]) begin
            if (!r_out_valid || i_m_tready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out[31:0];
    assign o_m_tuser  = {r_out[33], r_out[32]};

    `RCSD_ASSERT(a_skid_needs_out, !r_skid_full || r_out_valid)
    `RCSD_ASSERT(a_nohit_all_ones, !(r_out_valid && r_out[33]) || (r_out[31:0] == 32'hFFFF_FFFF))
    `RCSD_ASSERT_NEXT(a_skid_holds, r_skid_full && !i_m_tready, r_skid_full)
endmodule
